/* sv/srq_pkg.sv */
// ----------------------------------------------------------------------------
// srq_pkg: shared types and constants for the sensor ring query core
// Ring geometry, request codes, sequencer states and channel selects.
// ----------------------------------------------------------------------------
package srq_pkg;

   // Ring geometry
   localparam int RING_DEPTH = 16;
   localparam int PTR_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int CNT_W      = $clog2(RING_DEPTH + 1);

   // One RAM row holds a sample set: A [7:0], B [15:8], C [47:16]
   localparam int BYTE_W = 8;
   localparam int WIDE_W = 32;
   localparam int ROW_W  = 2 * BYTE_W + WIDE_W;

   // Bit-serial divider
   localparam int DIV_STEPS = WIDE_W;
   localparam int STEP_W    = $clog2(DIV_STEPS);

   // Request codes
   localparam logic [7:0] CODE_LAST_A = 8'hA0;
   localparam logic [7:0] CODE_LAST_B = 8'hA1;
   localparam logic [7:0] CODE_LAST_C = 8'hA2;
   localparam logic [7:0] CODE_MEAN_A = 8'hA3;
   localparam logic [7:0] CODE_MEAN_B = 8'hA4;
   localparam logic [7:0] CODE_MEAN_C = 8'hA5;

   // Item kinds carried on tuser
   localparam logic OP_PUSH  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_READ = 5'b00010,
      S_SCAN = 5'b00100,
      S_DIV  = 5'b01000,
      S_DONE = 5'b10000
   } state_type;

   typedef enum logic [1:0] {
      CHAN_A = 2'd0,
      CHAN_B = 2'd1,
      CHAN_C = 2'd2
   } chan_type;

   // True for the six codes the core answers
   function automatic logic code_known(input logic [7:0] code);
      code_known = (code == CODE_LAST_A) || (code == CODE_LAST_B) ||
                   (code == CODE_LAST_C) || (code == CODE_MEAN_A) ||
                   (code == CODE_MEAN_B) || (code == CODE_MEAN_C);
   endfunction

endpackage

/* sv/sensor_ring_last_and_mean_query_core.sv */
// ----------------------------------------------------------------------------
// sensor_ring_last_and_mean_query_core: three sample rings with queries
// Push beats store one sample set at a shared write pointer; query beats
// return the newest sample of a channel or the mean of its leading
// nonzero entries.
// ----------------------------------------------------------------------------
//  channel | ports            | tdata (low bit up)                  | tuser
//  --------+------------------+-------------------------------------+---------
//  request | req_t*  (in)     | sample_a, sample_b, sample_c,       | opcode
//          |                  | request_code                        |
//  result  | rsp_t*  (out)    | echo_code, answer_value             | code_invalid
//
//  Mean query: after the start, entries are read one per cycle through the
//  single RAM read port (the first zero entry included), then the
//  bit-serial divider runs unless no entry was summed, then the result is
//  loaded. An invalid code goes straight to loading a zero answer.
//  Reset clears the per-entry valid bits at once; no clearing pass.
//  A finished result waits in the output register; push beats are taken
//  meanwhile; a further query runs, then waits for the register to empty.
// ----------------------------------------------------------------------------
module sensor_ring_last_and_mean_query_core
   import srq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // sample_a[7:0], sample_b[15:8],
                                    // sample_c[47:16], request_code[55:48]
   input  logic        req_tuser,   // opcode[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // echo_code[7:0], answer_value[39:8]
   output logic        rsp_tuser    // code_invalid[0]
);

   state_type             state_ff, state_in;
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [RING_DEPTH-1:0] valid_ff, valid_in;
   logic [PTR_W-1:0]      scan_idx_ff, scan_idx_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [WIDE_W-1:0]     acc_ff, acc_in;
   logic [CNT_W-1:0]      rem_ff, rem_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [7:0]            code_ff, code_in;
   chan_type              chan_ff, chan_in;
   logic                  mean_ff, mean_in;
   logic                  rd_valid_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            rsp_code_ff, rsp_code_in;
   logic [WIDE_W-1:0]     rsp_answer_ff, rsp_answer_in;
   logic                  rsp_invalid_ff, rsp_invalid_in;

   logic                  ram_wr_en;
   logic [PTR_W-1:0]      ram_rd_addr;
   logic [ROW_W-1:0]      ram_rd_data;
   logic [ROW_W-1:0]      entry;
   logic [WIDE_W-1:0]     field;
   logic [15:0]           sum_short;
   logic [WIDE_W-1:0]     sum_next;
   logic [PTR_W-1:0]      newest_idx;
   logic                  scan_last;
   logic                  ptr_last;
   logic [CNT_W:0]        trial;
   logic [CNT_W:0]        diff;
   logic                  ge;
   logic                  slot_free;

   // Ring storage: one row per sample set
   srq_ram #(
      .WIDTH (ROW_W),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wr_ptr_ff),
      .wr_data (req_tdata[ROW_W-1:0]),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Pointer arithmetic
   assign ptr_last   = (wr_ptr_ff == PTR_W'(RING_DEPTH - 1));
   assign newest_idx = (wr_ptr_ff == '0) ? PTR_W'(RING_DEPTH - 1) : wr_ptr_ff - 1'b1;
   assign scan_last  = (scan_idx_ff == PTR_W'(RING_DEPTH - 1));

   // Read address: first read from READ, next entry prefetched during SCAN
   always_comb begin
      case (state_ff)
         S_READ:  ram_rd_addr = mean_ff ? scan_idx_ff : newest_idx;
         S_SCAN:  ram_rd_addr = scan_last ? '0 : scan_idx_ff + 1'b1;
         default: ram_rd_addr = '0;
      endcase
   end

   // Track whether the row being read was ever written
   always_ff @(posedge clock) begin
      rd_valid_ff <= valid_ff[ram_rd_addr];
   end

   // Select the channel field of the returned row; unwritten rows read zero
   assign entry = rd_valid_ff ? ram_rd_data : '0;

   always_comb begin
      case (chan_ff)
         CHAN_A:  field = WIDE_W'(entry[BYTE_W-1:0]);
         CHAN_B:  field = WIDE_W'(entry[2*BYTE_W-1:BYTE_W]);
         CHAN_C:  field = entry[ROW_W-1:2*BYTE_W];
         default: field = '0;
      endcase
   end

   // Running sum: 16-bit wrap for byte channels, 32-bit for the wide one
   assign sum_short = acc_ff[15:0] + field[15:0];

   always_comb begin
      if (chan_ff == CHAN_C) begin
         sum_next = acc_ff + field;
      end else begin
         sum_next = {16'd0, sum_short};
      end
   end

   // Restoring divider step: quotient shifts into acc_ff
   assign trial = {rem_ff, acc_ff[WIDE_W-1]};
   assign diff  = trial - {1'b0, count_ff};
   assign ge    = (trial >= {1'b0, count_ff});

   assign slot_free = !rsp_valid_ff || rsp_tready;

   // Sequencer
   always_comb begin
      state_in       = state_ff;
      wr_ptr_in      = wr_ptr_ff;
      valid_in       = valid_ff;
      scan_idx_in    = scan_idx_ff;
      count_in       = count_ff;
      acc_in         = acc_ff;
      rem_in         = rem_ff;
      step_in        = step_ff;
      code_in        = code_ff;
      chan_in        = chan_ff;
      mean_in        = mean_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_code_in    = rsp_code_ff;
      rsp_answer_in  = rsp_answer_ff;
      rsp_invalid_in = rsp_invalid_ff;
      ram_wr_en      = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser == OP_PUSH) begin
                  // Store the sample set and advance the pointer
                  ram_wr_en           = 1'b1;
                  valid_in[wr_ptr_ff] = 1'b1;
                  wr_ptr_in           = ptr_last ? '0 : wr_ptr_ff + 1'b1;
               end else begin
                  code_in     = req_tdata[55:48];
                  acc_in      = '0;
                  scan_idx_in = '0;
                  count_in    = '0;
                  rem_in      = '0;
                  step_in     = '0;
                  state_in    = S_READ;
                  case (req_tdata[55:48])
                     CODE_LAST_A: begin chan_in = CHAN_A; mean_in = 1'b0; end
                     CODE_LAST_B: begin chan_in = CHAN_B; mean_in = 1'b0; end
                     CODE_LAST_C: begin chan_in = CHAN_C; mean_in = 1'b0; end
                     CODE_MEAN_A: begin chan_in = CHAN_A; mean_in = 1'b1; end
                     CODE_MEAN_B: begin chan_in = CHAN_B; mean_in = 1'b1; end
                     CODE_MEAN_C: begin chan_in = CHAN_C; mean_in = 1'b1; end
                     default: begin
                        // Unknown code answers zero right away
                        state_in = S_DONE;
                     end
                  endcase
               end
            end
         end

         S_READ: begin
            state_in = S_SCAN;
         end

         S_SCAN: begin
            if (!mean_ff) begin
               acc_in   = field;
               state_in = S_DONE;
            end else if (field != '0) begin
               // Accumulate and move on; stop after the last ring slot
               acc_in   = sum_next;
               count_in = count_ff + 1'b1;
               if (scan_last) begin
                  state_in = S_DIV;
               end else begin
                  scan_idx_in = scan_idx_ff + 1'b1;
               end
            end else begin
               state_in = S_DIV;
            end
         end

         S_DIV: begin
            if (count_ff == '0) begin
               acc_in   = '0;
               state_in = S_DONE;
            end else begin
               acc_in  = {acc_ff[WIDE_W-2:0], ge};
               rem_in  = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
               step_in = step_ff + 1'b1;
               if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
                  state_in = S_DONE;
               end
            end
         end

         S_DONE: begin
            // Hold until the output register can take the beat
            if (slot_free) begin
               rsp_valid_in   = 1'b1;
               rsp_code_in    = code_ff;
               rsp_answer_in  = acc_ff;
               rsp_invalid_in = !code_known(code_ff);
               state_in       = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wr_ptr_ff    <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_ptr_ff    <= wr_ptr_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      scan_idx_ff    <= scan_idx_in;
      count_ff       <= count_in;
      acc_ff         <= acc_in;
      rem_ff         <= rem_in;
      step_ff        <= step_in;
      code_ff        <= code_in;
      chan_ff        <= chan_in;
      mean_ff        <= mean_in;
      rsp_code_ff    <= rsp_code_in;
      rsp_answer_ff  <= rsp_answer_in;
      rsp_invalid_ff <= rsp_invalid_in;
   end

   // Ports
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_answer_ff, rsp_code_ff};
   assign rsp_tuser  = rsp_invalid_ff;

   // Checks
   a_push_advances: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tuser == OP_PUSH)) |=>
      (wr_ptr_ff == (($past(wr_ptr_ff) == PTR_W'(RING_DEPTH - 1)) ?
                     PTR_W'(0) : $past(wr_ptr_ff) + 1'b1)))
      else $error("write pointer did not advance on push");

   a_query_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tuser == OP_QUERY)) |=> (state_ff != S_IDLE))
      else $error("query beat left the sequencer idle");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (count_ff <= CNT_W'(RING_DEPTH)))
      else $error("scan count beyond ring depth");

   a_done_delivers: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_DONE) && slot_free) |=> (rsp_valid_ff && (state_ff == S_IDLE)))
      else $error("finished query not loaded into output register");

   a_push_no_result: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tuser == OP_PUSH) && !rsp_valid_ff) |=>
      !rsp_valid_ff)
      else $error("push beat produced a result");

endmodule

/* sv/srq_ram.sv */
// ----------------------------------------------------------------------------
// srq_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module srq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write on enable, read every cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
